// File: sv/stw_pkg.sv
// Package for the up/down h:m:s stopwatch: command codes, field widths,
// limits, control structs and small decimal helper functions.
// No dependencies.
`default_nettype none

package stw_pkg;

  localparam int unsigned EntryDigits = 8;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned DigitW = 4;
  localparam int unsigned HundW  = 7;
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned CountW = 4;
  localparam int unsigned RawW   = 7;

  localparam logic [HundW-1:0]  HundMax    = 7'd99;
  localparam logic [SecW-1:0]   SecMax     = 6'd59;
  localparam logic [MinW-1:0]   MinMax     = 6'd59;
  localparam logic [HourW-1:0]  HourMax    = 5'd23;
  localparam logic [RawW-1:0]   BaseSixty  = 7'd60;
  localparam logic [RawW-1:0]   HoursDay   = 7'd24;
  localparam logic [DigitW-1:0] DigitMax   = 4'd9;
  localparam logic [CountW-1:0] EntryFull  = CountW'(EntryDigits);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 3'd0,
    CMD_DIGIT  = 3'd1,
    CMD_LOAD   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_TOGGLE = 3'd4
  } cmd_e;

  // Command issued to the state units in the cycle it is executed.
  typedef struct packed {
    logic              fire;
    cmd_e              cmd;
    logic [DigitW-1:0] digit;
  } op_t;

  // Raw two-digit fields of the entry, before normalization.
  typedef struct packed {
    logic            nonempty;
    logic [RawW-1:0] cc;
    logic [RawW-1:0] ss;
    logic [RawW-1:0] mm;
    logic [RawW-1:0] hh;
  } entry_t;

  typedef struct packed {
    logic [HundW-1:0] hund;
    logic [SecW-1:0]  sec;
    logic [MinW-1:0]  min;
    logic [HourW-1:0] hour;
    logic             running;
    logic             at_zero;
  } time_t;

  function automatic logic [RawW-1:0] dec2(input logic [DigitW-1:0] tens,
                                           input logic [DigitW-1:0] units);
    logic [RawW-1:0] t;
    t = RawW'(tens);
    return (t << 3) + (t << 1) + RawW'(units);
  endfunction

  // Values up to 119 only: four conditional subtracts.
  function automatic logic [HourW-1:0] mod24(input logic [RawW-1:0] v);
    logic [RawW-1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= HoursDay) begin
        r = r - HoursDay;
      end
    end
    return r[HourW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/stw_if.sv
// Valid/ready channel interfaces for the stopwatch: command in, time out.
// Depends on stw_pkg.
`default_nettype none

interface stw_cmd_if;
  import stw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [DigitW-1:0] digit;
  modport source (output valid, command, digit, input ready);
  modport sink   (input valid, command, digit, output ready);
endinterface

interface stw_res_if;
  import stw_pkg::*;
  logic              valid;
  logic              ready;
  logic [HundW-1:0]  hundredths;
  logic [SecW-1:0]   seconds_out;
  logic [MinW-1:0]   minutes_out;
  logic [HourW-1:0]  hours_out;
  logic              running_out;
  logic [CountW-1:0] entered_count;
  logic              at_zero;
  modport source (output valid, hundredths, seconds_out, minutes_out, hours_out,
                  running_out, entered_count, at_zero, input ready);
  modport sink   (input valid, hundredths, seconds_out, minutes_out, hours_out,
                  running_out, entered_count, at_zero, output ready);
endinterface

`default_nettype wire

// File: sv/stw_entry.sv
// Digit entry shift register with digit count; presents raw two-digit fields.
// Depends on stw_pkg.
`default_nettype none

module stw_entry (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stw_pkg::op_t             op_i,
  output stw_pkg::entry_t          entry_o,
  output logic [stw_pkg::CountW-1:0] count_o
);
  import stw_pkg::*;

  logic [DigitW-1:0] digits_q [EntryDigits];
  logic [DigitW-1:0] digits_d [EntryDigits];
  logic [CountW-1:0] count_q, count_d;

  always_comb begin
    digits_d = digits_q;
    count_d  = count_q;
    if (op_i.fire) begin
      case (op_i.cmd)
        CMD_DIGIT: begin
          if (op_i.digit <= DigitMax) begin
            if (count_q >= EntryFull) begin
              // full entry: restart with this digit
              for (int i = 1; i < EntryDigits; i++) begin
                digits_d[i] = '0;
              end
              count_d = CountW'(1);
            end else begin
              for (int i = 1; i < EntryDigits; i++) begin
                digits_d[i] = digits_q[i-1];
              end
              count_d = count_q + CountW'(1);
            end
            digits_d[0] = op_i.digit;
          end
        end
        CMD_LOAD: begin
          if (count_q != '0) begin
            for (int i = 0; i < EntryDigits; i++) begin
              digits_d[i] = '0;
            end
            count_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EntryDigits; i++) begin
        digits_q[i] <= '0;
      end
      count_q <= '0;
    end else begin
      digits_q <= digits_d;
      count_q  <= count_d;
    end
  end

  assign entry_o.nonempty = (count_q != '0);
  assign entry_o.cc       = dec2(digits_q[1], digits_q[0]);
  assign entry_o.ss       = dec2(digits_q[3], digits_q[2]);
  assign entry_o.mm       = dec2(digits_q[5], digits_q[4]);
  assign entry_o.hh       = dec2(digits_q[7], digits_q[6]);
  assign count_o          = count_q;

endmodule

`default_nettype wire

// File: sv/stw_time.sv
// Time registers and run flag: up/down tick, load with normalization,
// clear and run toggle. Depends on stw_pkg.
`default_nettype none

module stw_time (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stw_pkg::op_t    op_i,
  input  logic            count_down_i,
  input  stw_pkg::entry_t entry_i,
  output stw_pkg::time_t  time_o
);
  import stw_pkg::*;

  logic [HundW-1:0] hund_q, hund_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [HourW-1:0] hour_q, hour_d;
  logic             running_q, running_d;
  logic             at_zero_q, at_zero_d;
  logic [RawW-1:0]  ld_ss, ld_mm, ld_hh;

  always_comb begin
    ld_ss = entry_i.ss;
    ld_mm = entry_i.mm;
    ld_hh = entry_i.hh;
    if (ld_ss >= BaseSixty) begin
      ld_ss = ld_ss - BaseSixty;
      ld_mm = ld_mm + RawW'(1);
    end
    if (ld_mm >= BaseSixty) begin
      ld_mm = ld_mm - BaseSixty;
      ld_hh = ld_hh + RawW'(1);
    end
  end

  always_comb begin
    hund_d    = hund_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    running_d = running_q;
    if (op_i.fire) begin
      case (op_i.cmd)
        CMD_TICK: begin
          if (running_q && !count_down_i) begin
            if (hund_q < HundMax) begin
              hund_d = hund_q + HundW'(1);
            end else begin
              hund_d = '0;
              if (sec_q < SecMax) begin
                sec_d = sec_q + SecW'(1);
              end else begin
                sec_d = '0;
                if (min_q < MinMax) begin
                  min_d = min_q + MinW'(1);
                end else begin
                  min_d  = '0;
                  hour_d = (hour_q < HourMax) ? hour_q + HourW'(1) : '0;
                end
              end
            end
          end else if (running_q) begin
            if (hund_q != '0) begin
              hund_d = hund_q - HundW'(1);
            end else if (sec_q != '0) begin
              sec_d  = sec_q - SecW'(1);
              hund_d = HundMax;
            end else if (min_q != '0) begin
              min_d  = min_q - MinW'(1);
              sec_d  = SecMax;
              hund_d = HundMax;
            end else if (hour_q != '0) begin
              hour_d = hour_q - HourW'(1);
              min_d  = MinMax;
              sec_d  = SecMax;
              hund_d = HundMax;
            end
          end
        end
        CMD_LOAD: begin
          if (entry_i.nonempty) begin
            hund_d    = entry_i.cc;
            sec_d     = ld_ss[SecW-1:0];
            min_d     = ld_mm[MinW-1:0];
            hour_d    = mod24(ld_hh);
            running_d = 1'b1;
          end
        end
        CMD_CLEAR: begin
          hund_d = '0;
          sec_d  = '0;
          min_d  = '0;
          hour_d = '0;
        end
        CMD_TOGGLE: begin
          running_d = !running_q;
        end
        default: begin
        end
      endcase
    end
    at_zero_d = (hund_d == '0) && (sec_d == '0) && (min_d == '0) && (hour_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hund_q    <= '0;
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      running_q <= 1'b0;
      at_zero_q <= 1'b1;
    end else begin
      hund_q    <= hund_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      running_q <= running_d;
      at_zero_q <= at_zero_d;
    end
  end

  assign time_o.hund    = hund_q;
  assign time_o.sec     = sec_q;
  assign time_o.min     = min_q;
  assign time_o.hour    = hour_q;
  assign time_o.running = running_q;
  assign time_o.at_zero = at_zero_q;

endmodule

`default_nettype wire

// File: sv/up_down_hms_stopwatch.sv
// Up/down h:m:s.cc stopwatch top level: command input register, state units
// and result handshake. Depends on stw_pkg, stw_if, stw_entry, stw_time.
//
//   port      dir  kind         payload
//   cmd_i     in   valid/ready  command, digit
//   res_o     out  valid/ready  time fields, running_out, entered_count, at_zero
//   cfg_*     in   write only   count_down (1 bit)
//
// One command per cycle sustained while res_o takes results; each command
// passes the input register, then the state update into the result.
// The state registers are the result register; they update only when the
// result slot is empty or being taken, so a stalled output holds the input
// register, and cmd_i.ready drops only when both are full and res_o stalls.
// Reset clears time, run flag, entry and count_down; no clearing pass.
`default_nettype none

module up_down_hms_stopwatch (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  stw_cmd_if.sink        cmd_i,
  stw_res_if.source      res_o
);
  import stw_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [CmdW-1:0]   s1_cmd_q;
  logic [DigitW-1:0] s1_digit_q;
  logic              out_valid_q, out_valid_d;
  logic              count_down_q;
  logic              s2_free;
  op_t               op;
  entry_t            entry;
  time_t             tm;
  logic [CountW-1:0] count;

  assign s2_free     = !out_valid_q || res_o.ready;
  assign cmd_i.ready = !s1_valid_q || s2_free;

  assign op.fire  = s1_valid_q && s2_free;
  assign op.cmd   = cmd_e'(s1_cmd_q);
  assign op.digit = s1_digit_q;

  always_comb begin
    s1_valid_d  = cmd_i.ready ? cmd_i.valid : s1_valid_q;
    out_valid_d = op.fire ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      count_down_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_down_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      s1_cmd_q   <= cmd_i.command;
      s1_digit_q <= cmd_i.digit;
    end
  end

  stw_entry u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .entry_o (entry),
    .count_o (count)
  );

  stw_time u_time (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .count_down_i (count_down_q),
    .entry_i      (entry),
    .time_o       (tm)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.hundredths    = tm.hund;
  assign res_o.seconds_out   = tm.sec;
  assign res_o.minutes_out   = tm.min;
  assign res_o.hours_out     = tm.hour;
  assign res_o.running_out   = tm.running;
  assign res_o.entered_count = count;
  assign res_o.at_zero       = tm.at_zero;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.hundredths <= HundMax) && (res_o.seconds_out <= SecMax) &&
                    (res_o.minutes_out <= MinMax) && (res_o.hours_out <= HourMax))
    else $error("time field out of range");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.at_zero == ((res_o.hundredths == '0) &&
      (res_o.seconds_out == '0) && (res_o.minutes_out == '0) && (res_o.hours_out == '0)))
    else $error("at_zero disagrees with time fields");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.entered_count <= EntryFull)
    else $error("entry count above capacity");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> (s1_valid_q && $stable(s1_cmd_q) && $stable(s1_digit_q)))
    else $error("stalled command lost from input register");

endmodule

`default_nettype wire

// File: verif/stw_checker.sv
`timescale 1ns / 1ps
// Checker for the up/down h:m:s stopwatch: watches command and result transfers,
// predicts each result from its own copy of the timer state and compares fields.
// Depends on stw_pkg and stw_if.
module stw_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  stw_cmd_if   cmd_mon,
  stw_res_if   res_mon,
  output int   errors_o,
  output int   pending_o
);
  import stw_pkg::*;

  typedef struct packed {
    logic [HundW-1:0]  hund;
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   min;
    logic [HourW-1:0]  hour;
    logic              running;
    logic [CountW-1:0] count;
    logic              at_zero;
  } watch_t;

  logic              down_mode;
  logic [HundW-1:0]  hund_q;
  logic [SecW-1:0]   sec_q;
  logic [MinW-1:0]   min_q;
  logic [HourW-1:0]  hour_q;
  logic              running_q;
  logic [DigitW-1:0] entry_q [EntryDigits];
  logic [CountW-1:0] count_q;
  watch_t            watch_q [$];
  watch_t            want;
  int                error_count = 0;

  function automatic void wipe_entry();
    foreach (entry_q[i]) entry_q[i] = '0;
    count_q = '0;
  endfunction

  function automatic void advance_time();
    if (hund_q < HundMax) begin
      hund_q++;
      return;
    end
    hund_q = '0;
    if (sec_q < SecMax) begin
      sec_q++;
      return;
    end
    sec_q = '0;
    if (min_q < MinMax) begin
      min_q++;
      return;
    end
    min_q  = '0;
    hour_q = (hour_q < HourMax) ? hour_q + 1'b1 : '0;
  endfunction

  // borrow reloads every lower field; holds at zero
  function automatic void rewind_time();
    if (hund_q != '0) begin
      hund_q--;
      return;
    end
    if (sec_q != '0) begin
      sec_q--;
    end else if (min_q != '0) begin
      min_q--;
      sec_q = SecMax;
    end else if (hour_q != '0) begin
      hour_q--;
      min_q = MinMax;
      sec_q = SecMax;
    end else begin
      return;
    end
    hund_q = HundMax;
  endfunction

  function automatic void push_digit(logic [DigitW-1:0] d);
    if (d > DigitMax) return;
    if (count_q >= EntryFull) wipe_entry();
    for (int i = EntryDigits - 1; i > 0; i--) entry_q[i] = entry_q[i-1];
    entry_q[0] = d;
    count_q++;
  endfunction

  function automatic void load_entry();
    int cc, ss, mm, hh;
    if (count_q == '0) return;
    cc = 10 * int'(entry_q[1]) + int'(entry_q[0]);
    ss = 10 * int'(entry_q[3]) + int'(entry_q[2]);
    mm = 10 * int'(entry_q[5]) + int'(entry_q[4]);
    hh = 10 * int'(entry_q[7]) + int'(entry_q[6]);
    if (ss >= 60) begin
      ss -= 60;
      mm++;
    end
    if (mm >= 60) begin
      mm -= 60;
      hh++;
    end
    hh        = hh % 24;
    hund_q    = HundW'(cc);
    sec_q     = SecW'(ss);
    min_q     = MinW'(mm);
    hour_q    = HourW'(hh);
    running_q = 1'b1;
    wipe_entry();
  endfunction

  function automatic watch_t apply_command(logic [CmdW-1:0] code, logic [DigitW-1:0] d);
    watch_t w;
    case (code)
      CMD_TICK: begin
        if (running_q) begin
          if (down_mode) rewind_time();
          else advance_time();
        end
      end
      CMD_DIGIT:  push_digit(d);
      CMD_LOAD:   load_entry();
      CMD_CLEAR: begin
        hund_q = '0;
        sec_q  = '0;
        min_q  = '0;
        hour_q = '0;
      end
      CMD_TOGGLE: running_q = ~running_q;
      default: ;
    endcase
    w.hund    = hund_q;
    w.sec     = sec_q;
    w.min     = min_q;
    w.hour    = hour_q;
    w.running = running_q;
    w.count   = count_q;
    w.at_zero = (hund_q == '0) && (sec_q == '0) && (min_q == '0) && (hour_q == '0);
    return w;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      error_count++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_mode = 1'b0;
      hund_q    = '0;
      sec_q     = '0;
      min_q     = '0;
      hour_q    = '0;
      running_q = 1'b0;
      wipe_entry();
      watch_q.delete();
    end else begin
      if (cfg_we_i) down_mode = cfg_wdata_i;
      if (res_mon.valid && res_mon.ready) begin
        if (watch_q.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: expected none, actual %0d:%0d:%0d.%0d",
                   $time, res_mon.hours_out, res_mon.minutes_out,
                   res_mon.seconds_out, res_mon.hundredths);
        end else begin
          want = watch_q.pop_front();
          check_field("hundredths", 8'(want.hund), 8'(res_mon.hundredths));
          check_field("seconds", 8'(want.sec), 8'(res_mon.seconds_out));
          check_field("minutes", 8'(want.min), 8'(res_mon.minutes_out));
          check_field("hours", 8'(want.hour), 8'(res_mon.hours_out));
          check_field("running", 8'(want.running), 8'(res_mon.running_out));
          check_field("entered_count", 8'(want.count), 8'(res_mon.entered_count));
          check_field("at_zero", 8'(want.at_zero), 8'(res_mon.at_zero));
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        watch_q.push_back(apply_command(cmd_mon.command, cmd_mon.digit));
      end
    end
    pending_o <= watch_q.size();
    errors_o  <= error_count;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the stopwatch testbench: clock, reset, command stimulus in bursts,
// result back-pressure and the verdict. Depends on stw_pkg, stw_if,
// up_down_hms_stopwatch and stw_checker.
module testbench;
  import stw_pkg::*;

  localparam int RandomItems = 1150;
  localparam int CycleLimit  = 200000;
  localparam int LongStall   = 80;

  localparam logic [CmdW-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CmdW-1:0] CMD_SPARE_HI = 3'd7;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  int   errors;
  int   pending;
  int   cycles       = 0;
  int   items        = 0;
  int   stall_reqs   = 0;
  int   stall_served = 0;
  int   burst_left   = 0;
  bit   no_gaps      = 1'b0;

  stw_cmd_if cmd_if ();
  stw_res_if res_if ();

  up_down_hms_stopwatch dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  stw_checker chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .cmd_mon   (cmd_if),
    .res_mon   (res_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("up_down_hms_stopwatch test failed");
      $finish;
    end
  end

  // result side: stall pattern of its own, plus long holds on request
  initial begin : receiver
    int mode;
    int span;
    int phase;
    res_if.ready = 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk_i);
        if (stall_served != stall_reqs) begin
          stall_served++;
          res_if.ready <= 1'b0;
          repeat (LongStall) @(posedge clk_i);
        end
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 3) != 0);
          2:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (phase % 3 != 0);
        endcase
        phase++;
      end
    end
  end

  task automatic issue(input logic [CmdW-1:0] code, input logic [DigitW-1:0] d);
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= code;
    cmd_if.digit   <= d;
    do @(posedge clk_i); while (!cmd_if.ready);
    items++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // sender pauses until every transfer has its result
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_mode(input logic down);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= down;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [DigitW-1:0] rand_digit();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return '0;
    if (k == 3) return DigitMax;
    return DigitW'($urandom_range(0, 9));
  endfunction

  task automatic enter_time(input int hh, input int mm, input int ss, input int cc);
    int f [4];
    f = '{hh, mm, ss, cc};
    foreach (f[i]) begin
      issue(CMD_DIGIT, DigitW'(f[i] / 10));
      issue(CMD_DIGIT, DigitW'(f[i] % 10));
    end
  endtask

  task automatic load_random_entry();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    repeat (n) issue(CMD_DIGIT, rand_digit());
    issue(CMD_LOAD, rand_digit());
    repeat ($urandom_range(1, 40)) issue(CMD_TICK, DigitW'($urandom_range(0, 15)));
  endtask

  task automatic load_edge_time();
    int hh_set [4] = '{0, 1, 23, 24};
    int ms_set [3] = '{0, 1, 59};
    int cc_set [4] = '{0, 1, 98, 99};
    enter_time(hh_set[$urandom_range(0, 3)], ms_set[$urandom_range(0, 2)],
               ms_set[$urandom_range(0, 2)], cc_set[$urandom_range(0, 3)]);
    issue(CMD_LOAD, '0);
    repeat ($urandom_range(1, 6)) issue(CMD_TICK, '0);
  endtask

  initial begin : stimulus
    int  k;
    int  next_switch;
    logic down;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_TICK;
    cmd_if.digit   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: counting up
    write_mode(1'b0);
    issue(CMD_TICK, '0);
    issue(CMD_SPARE_LO, '0);
    issue(CMD_SPARE_HI, '1);
    issue(CMD_DIGIT, '1);
    repeat (8) issue(CMD_DIGIT, DigitMax);
    issue(CMD_LOAD, '0);
    enter_time(23, 59, 59, 99);
    issue(CMD_LOAD, '0);
    issue(CMD_TICK, '0);
    issue(CMD_CLEAR, '0);
    issue(CMD_TOGGLE, '0);

    // directed: counting down, empty load and hold at zero
    write_mode(1'b1);
    issue(CMD_LOAD, '0);
    issue(CMD_DIGIT, 4'd1);
    issue(CMD_LOAD, '0);
    issue(CMD_TICK, '0);
    issue(CMD_TICK, '0);

    // backlog while the result side holds off
    stall_reqs <= stall_reqs + 1;
    no_gaps = 1'b1;
    load_random_entry();
    repeat (30) issue(CMD_TICK, '0);
    no_gaps = 1'b0;

    down        = 1'b1;
    next_switch = items + $urandom_range(100, 250);
    items       = 0;
    next_switch = $urandom_range(100, 250);
    while (items < RandomItems) begin
      if (items >= next_switch) begin
        down = ~down;
        write_mode(down);
        next_switch = items + $urandom_range(100, 250);
        if ($urandom_range(0, 2) == 0) begin
          stall_reqs <= stall_reqs + 1;
          no_gaps = 1'b1;
          repeat (30) issue(CMD_TICK, DigitW'($urandom_range(0, 15)));
          no_gaps = 1'b0;
        end
      end
      k = $urandom_range(0, 19);
      if (k < 6) begin
        load_random_entry();
      end else if (k < 8) begin
        load_edge_time();
      end else if (k < 13) begin
        repeat ($urandom_range(1, 40)) issue(CMD_TICK, DigitW'($urandom_range(0, 15)));
      end else if (k == 13) begin
        issue(CMD_TOGGLE, rand_digit());
        repeat ($urandom_range(0, 5)) issue(CMD_TICK, '0);
        issue(CMD_TOGGLE, rand_digit());
      end else if (k == 14) begin
        issue(CMD_CLEAR, rand_digit());
      end else if (k == 15) begin
        issue(CMD_DIGIT, DigitW'($urandom_range(10, 15)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          issue(CmdW'($urandom_range(0, 7)), DigitW'($urandom_range(0, 15)));
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("up_down_hms_stopwatch test passed");
    end else begin
      $display("up_down_hms_stopwatch test failed");
    end
    $finish;
  end

endmodule
